// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files of the frame parser.
// Each macro expects signals named aclk and aresetn in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFPC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UFPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ufpc_pkg.sv -----
// Types and constants of the UART frame parser.
// Used by ufpc_parser and by the top level uart_frame_parser_checksum.
package ufpc_pkg;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_VER,
        PH_CMD,
        PH_PAY,
        PH_SUM
    } phase_t;

    // Packed so that frame_len sits in the lowest bits.
    typedef struct packed {
        logic [7:0]  frame_sum;
        logic [7:0]  payload;
        logic [7:0]  command;
        logic [7:0]  version;
        logic [15:0] frame_len;
    } frame_t;

    typedef struct packed {
        logic   ok;
        frame_t frame;
    } parse_result_t;

    localparam int unsigned FRAME_BITS = $bits(frame_t);

    localparam logic CFG_HEADER_VALUE  = 1'b0;
    localparam logic CFG_TIMEOUT_TICKS = 1'b1;

    localparam logic ACTION_BYTE = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    localparam logic [7:0]  HEADER_RESET  = 8'd0;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

endpackage

// ----- hw/rtl/uart_frame_parser_checksum.sv -----
// Top level of the UART fixed-frame parser with additive checksum.
// Depends on ufpc_pkg, ufpc_parser and assert_macros.svh.
//
// Use: the slave channel carries one item per handshake, either a received
// UART byte (s_tuser = 0, byte in s_tdata) or one elapsed time tick
// (s_tuser = 1). Seven bytes form a frame: header, length high, length low,
// version, command, payload and checksum. A frame whose checksum equals the
// low eight bits of the sum of the first six bytes gives one item on the
// master channel; a bad frame gives none. A byte that arrives after more
// than timeout_ticks ticks restarts the parser before it is examined.
// A checksum byte's result is registered in the output or skid register.
// Throughput: one input item per cycle, limited only by the two-entry
// output buffer (output register plus skid register). When the receiver
// stalls, s_tready stays high until the skid register holds a result, so
// input keeps flowing through one stalled frame. The cfg channel writes
// header_value (index 0) and timeout_ticks (index 1); the user must do so
// only while the block is idle (not enforced); cfg_ready is always high.
// Reset (synchronous, aresetn low) returns the parser to header hunting,
// clears the gap counter, empties the output buffer and restores the
// registers to header 0 and timeout 1000.
`include "assert_macros.svh"

module uart_frame_parser_checksum import ufpc_pkg::*; #(
    parameter int unsigned GAP_COUNTER_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // rx_byte
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // frame_len[15:0], version[23:16], command[31:24], payload[39:32],
    // frame_sum[47:40]
    output logic [FRAME_BITS-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_addr,
    input  logic [15:0]           cfg_data
);

    logic [7:0]    header_reg;
    logic [15:0]   timeout_reg;
    logic          s_accept;
    logic          m_pop;
    parse_result_t parse_res;
    frame_t        out_reg, out_next;
    frame_t        skid_reg, skid_next;
    logic          out_valid_reg, out_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    logic          push;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign m_pop     = out_valid_reg && m_tready;
    assign push      = parse_res.ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg  <= HEADER_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_addr)
                CFG_HEADER_VALUE:  header_reg  <= cfg_data[7:0];
                CFG_TIMEOUT_TICKS: timeout_reg <= cfg_data;
                default:           header_reg  <= header_reg;
            endcase
        end
    end

    ufpc_parser #(
        .GAP_COUNTER_BITS(GAP_COUNTER_BITS)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (s_accept),
        .action        (s_tuser),
        .rx_byte       (s_tdata),
        .header_value  (header_reg),
        .timeout_ticks (timeout_reg),
        .result        (parse_res)
    );

    // Output register with a skid register behind it.
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg) begin
            out_next       = parse_res.frame;
            out_valid_next = push;
        end else if (m_pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                skid_next       = parse_res.frame;
                skid_valid_next = push;
            end else begin
                out_next       = parse_res.frame;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = parse_res.frame;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `UFPC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid register holds a frame while the output register is empty")
    `UFPC_ASSERT_SAME(a_tick_no_frame, s_accept && (s_tuser == ACTION_TICK), !parse_res.ok,
        "a tick item produced a frame")
    `UFPC_ASSERT_NEXT(a_frame_shows, parse_res.ok && !out_valid_reg, m_tvalid,
        "a good frame did not reach the output register")

endmodule

// ----- hw/rtl/ufpc_parser.sv -----
// Frame parser core: phase register, gap counter, field stores and checksum.
// Depends on ufpc_pkg for the phase enum and the result struct.
module ufpc_parser import ufpc_pkg::*; #(
    parameter int unsigned GAP_COUNTER_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  logic                action,
    input  logic [7:0]          rx_byte,
    input  logic [7:0]          header_value,
    input  logic [15:0]         timeout_ticks,
    output parse_result_t       result
);

    localparam int unsigned CMP_W = (GAP_COUNTER_BITS > 16) ? GAP_COUNTER_BITS : 16;
    localparam logic [GAP_COUNTER_BITS-1:0] GAP_MAX = {GAP_COUNTER_BITS{1'b1}};

    phase_t                      phase_reg, phase_next, phase_eff;
    logic [GAP_COUNTER_BITS-1:0] gap_reg, gap_next;
    logic [15:0]                 length_reg, length_next;
    logic [7:0]                  version_reg, version_next;
    logic [7:0]                  command_reg, command_next;
    logic [7:0]                  payload_reg, payload_next;
    logic [7:0]                  sum_reg, sum_next;
    logic                        byte_in;
    logic                        timed_out;

    assign byte_in   = item_valid && (action == ACTION_BYTE);
    assign timed_out = CMP_W'(gap_reg) > CMP_W'(timeout_ticks);
    // A byte after a long gap is parsed as if the parser were hunting.
    assign phase_eff = timed_out ? PH_HUNT : phase_reg;

    always_comb begin
        gap_next = gap_reg;
        if (item_valid) begin
            if (action == ACTION_TICK) begin
                if (gap_reg != GAP_MAX) begin
                    gap_next = gap_reg + 1'b1;
                end
            end else begin
                gap_next = '0;
            end
        end
    end

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (byte_in) begin
            case (phase_eff)
                PH_HUNT:   phase_next = (rx_byte == header_value) ? PH_LEN_HI : PH_HUNT;
                PH_LEN_HI: phase_next = PH_LEN_LO;
                PH_LEN_LO: phase_next = PH_VER;
                PH_VER:    phase_next = PH_CMD;
                PH_CMD:    phase_next = PH_PAY;
                PH_PAY:    phase_next = PH_SUM;
                PH_SUM:    phase_next = PH_HUNT;
                default:   phase_next = PH_HUNT;
            endcase
        end
    end

    // Field stores, running sum and the result.
    always_comb begin
        length_next  = length_reg;
        version_next = version_reg;
        command_next = command_reg;
        payload_next = payload_reg;
        sum_next     = sum_reg;
        result.ok    = 1'b0;
        result.frame.frame_len = length_reg;
        result.frame.version   = version_reg;
        result.frame.command   = command_reg;
        result.frame.payload   = payload_reg;
        result.frame.frame_sum = rx_byte;
        if (byte_in) begin
            case (phase_eff)
                PH_HUNT: begin
                    if (rx_byte == header_value) begin
                        sum_next = rx_byte;
                    end
                end
                PH_LEN_HI: begin
                    length_next = {rx_byte, 8'h00};
                    sum_next    = sum_reg + rx_byte;
                end
                PH_LEN_LO: begin
                    length_next = {length_reg[15:8], rx_byte};
                    sum_next    = sum_reg + rx_byte;
                end
                PH_VER: begin
                    version_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                end
                PH_CMD: begin
                    command_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                end
                PH_PAY: begin
                    payload_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                end
                PH_SUM: begin
                    result.ok = (rx_byte == sum_reg);
                end
                default: begin
                    result.ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            gap_reg     <= '0;
            length_reg  <= '0;
            version_reg <= '0;
            command_reg <= '0;
            payload_reg <= '0;
            sum_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            gap_reg     <= gap_next;
            length_reg  <= length_next;
            version_reg <= version_next;
            command_reg <= command_next;
            payload_reg <= payload_next;
            sum_reg     <= sum_next;
        end
    end

endmodule
